// ----- design/bsl1_pkg.sv -----
`timescale 1ns / 1ps
package bsl1_pkg;
    localparam int unsigned MaxItems = 1024;
    localparam int unsigned AddrW = $clog2(MaxItems);
    localparam int unsigned CntW = $clog2(MaxItems + 1);
    localparam int unsigned ValW = 48;
    localparam int unsigned CostW = 54;
    localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

    // Heap operation codes issued by the controller.
    typedef enum logic [1:0] {
        t_op_push = 2'd0,
        t_op_pop  = 2'd1
    } t_op;

    // Insertion case chosen for an accepted sample.
    typedef enum logic [1:0] {
        CASE_BOTH  = 2'd0,
        CASE_LEFT  = 2'd1,
        CASE_RIGHT = 2'd2
    } t_case;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_RDTOP, S_WTTOP, S_DECIDE, S_OP_START, S_OP_RUN, S_NEXT, S_OUT
    } t_state;

    // Command from controller to heap unit.
    typedef struct packed {
        logic            start;
        t_op             op;
        logic            right;
        logic [ValW-1:0] value;
    } t_heap_cmd;

    typedef struct packed {
        logic            busy;
        logic [ValW-1:0] ltop;
        logic [ValW-1:0] rtop;
        logic [CntW-1:0] lcnt;
        logic [CntW-1:0] rcnt;
    } t_heap_sts;
endpackage

// ----- design/bsl1_heap.sv -----
`timescale 1ns / 1ps
module bsl1_heap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsl1_pkg::t_heap_cmd i_cmd,
    output bsl1_pkg::t_heap_sts o_sts
);
    import bsl1_pkg::*;

    typedef enum logic [2:0] {
        H_IDLE, H_PUSH_RD, H_PUSH_CMP, H_POP_RDL, H_POP_RD, H_POP_CMP, H_WRITE
    } t_hstate;

    logic [ValW-1:0] r_mem_l [MaxItems];
    logic [ValW-1:0] r_mem_r [MaxItems];
    logic [ValW-1:0] r_rd_a, r_rd_b;
    logic [ValW-1:0] r_top_l, r_top_r;
    logic [CntW-1:0] r_cnt_l, r_cnt_r;
    t_hstate         r_st;
    logic            r_right;
    logic [ValW-1:0] r_val;
    logic [CntW-1:0] r_i, r_n;

    logic            we;
    logic [AddrW-1:0] wa, ra_a, ra_b;
    logic [ValW-1:0] wd;
    logic [CntW-1:0] par, c1, c2;

    assign par = (r_i - 1'b1) >> 1;
    assign c1  = {r_i[CntW-2:0], 1'b1};
    assign c2  = c1 + 1'b1;

    // Signed rank compare: max-heap on the left side, min-heap on the right.
    function automatic logic outranks(input logic rt, input logic [ValW-1:0] a,
                                      input logic [ValW-1:0] b);
        return rt ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
    endfunction

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (we && !r_right) r_mem_l[wa] <= wd;
        if (we && r_right)  r_mem_r[wa] <= wd;
        r_rd_a <= r_right ? r_mem_r[ra_a] : r_mem_l[ra_a];
        r_rd_b <= r_right ? r_mem_r[ra_b] : r_mem_l[ra_b];
    end

    logic sel_b;
    assign sel_b = (c2 < r_n) && outranks(r_right, r_rd_b, r_rd_a);

    always_comb begin
        we = 1'b0; wa = r_i[AddrW-1:0]; wd = r_val;
        ra_a = par[AddrW-1:0]; ra_b = par[AddrW-1:0];
        unique case (r_st)
            H_PUSH_RD:  ra_a = par[AddrW-1:0];
            H_POP_RDL:  ra_a = r_n[AddrW-1:0];
            H_POP_RD:  begin ra_a = c1[AddrW-1:0]; ra_b = c2[AddrW-1:0]; end
            H_PUSH_CMP: begin
                we = 1'b1;
                if (r_i != '0 && outranks(r_right, r_val, r_rd_a)) wd = r_rd_a;
            end
            H_POP_CMP: begin
                we = 1'b1;
                if (outranks(r_right, sel_b ? r_rd_b : r_rd_a, r_val))
                    wd = sel_b ? r_rd_b : r_rd_a;
            end
            H_WRITE: we = (r_n != '0);
            default: ;
        endcase
    end

    // Sift sequencer: each level runs a read state (H_PUSH_RD or H_POP_RD), then a compare state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= H_IDLE; r_cnt_l <= '0; r_cnt_r <= '0;
        end else begin
            unique case (r_st)
                H_IDLE: if (i_cmd.start) begin
                    r_right <= i_cmd.right;
                    r_val   <= i_cmd.value;
                    if (i_cmd.op == t_op_push) begin
                        r_i  <= i_cmd.right ? r_cnt_r : r_cnt_l;
                        r_st <= ((i_cmd.right ? r_cnt_r : r_cnt_l) == '0) ? H_WRITE : H_PUSH_RD;
                        r_n  <= CntW'(1);
                        if (i_cmd.right) r_cnt_r <= r_cnt_r + 1'b1;
                        else             r_cnt_l <= r_cnt_l + 1'b1;
                    end else begin
                        r_i  <= '0;
                        r_n  <= (i_cmd.right ? r_cnt_r : r_cnt_l) - 1'b1;
                        r_st <= H_POP_RDL;
                        if (i_cmd.right) r_cnt_r <= r_cnt_r - 1'b1;
                        else             r_cnt_l <= r_cnt_l - 1'b1;
                    end
                end
                H_PUSH_RD: r_st <= H_PUSH_CMP;
                H_PUSH_CMP: begin
                    if (outranks(r_right, r_val, r_rd_a)) begin
                        if (r_i == '0) r_st <= H_WRITE;
                        r_i <= par;
                        r_st <= (par == '0) ? H_WRITE : H_PUSH_RD;
                        if (par == '0 && !r_right) r_top_l <= r_val;
                        if (par == '0 && r_right)  r_top_r <= r_val;
                    end else begin
                        r_st <= H_IDLE;
                    end
                end
                H_POP_RDL: r_st <= H_POP_RD;
                H_POP_RD: begin
                    if (r_i == '0) r_val <= r_rd_a;
                    if (c1 >= r_n) r_st <= H_WRITE;
                    else           r_st <= H_POP_CMP;
                end
                H_POP_CMP: begin
                    if (outranks(r_right, sel_b ? r_rd_b : r_rd_a, r_val)) begin
                        if (r_i == '0 && !r_right) r_top_l <= sel_b ? r_rd_b : r_rd_a;
                        if (r_i == '0 && r_right)  r_top_r <= sel_b ? r_rd_b : r_rd_a;
                        r_i  <= sel_b ? c2 : c1;
                        r_st <= H_POP_RD;
                    end else begin
                        if (r_i == '0 && !r_right) r_top_l <= r_val;
                        if (r_i == '0 && r_right)  r_top_r <= r_val;
                        r_st <= H_IDLE;
                    end
                end
                H_WRITE: begin
                    if (r_i == '0 && !r_right) r_top_l <= r_val;
                    if (r_i == '0 && r_right)  r_top_r <= r_val;
                    r_st <= H_IDLE;
                end
                default: r_st <= H_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_st != H_IDLE);
    assign o_sts.ltop = r_top_l;
    assign o_sts.rtop = r_top_r;
    assign o_sts.lcnt = r_cnt_l;
    assign o_sts.rcnt = r_cnt_r;
endmodule

// ----- design/bsl1_ctrl.sv -----
`timescale 1ns / 1ps
module bsl1_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [31:0]         i_sample,
    input  logic [31:0]         i_step,
    input  logic                i_out_free,
    input  bsl1_pkg::t_heap_sts i_sts,
    output logic                o_in_ready,
    output bsl1_pkg::t_heap_cmd o_cmd,
    output logic                o_out_load,
    output logic [bsl1_pkg::CostW-1:0] o_cost,
    output logic                o_ovf
);
    import bsl1_pkg::*;

    t_state r_st, n_st;
    logic [ValW-1:0] r_loff, r_roff, r_v, r_a, r_b;
    logic [CostW-1:0] r_cost;
    logic r_started, r_ovf;
    t_case r_case;
    logic [1:0] r_k;

    logic [ValW-1:0] ltop, rtop, vl, vr, d;
    logic [CostW:0] sum;
    assign ltop = i_sts.ltop + r_loff;
    assign rtop = i_sts.rtop + r_roff;
    assign vl = r_v - r_loff;
    assign vr = r_v - r_roff;
    assign d = ($signed(r_v) <= $signed(ltop)) ? ltop - r_v : r_v - rtop;
    assign sum = {1'b0, r_cost} + {{(CostW+1-ValW){1'b0}}, d};

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:   if (i_in_valid) n_st = S_CHECK;
            S_CHECK:  n_st = r_ovf ? S_OUT : S_RDTOP;
            S_RDTOP:  n_st = S_DECIDE;
            S_WTTOP:  n_st = S_DECIDE;
            S_DECIDE: n_st = S_OP_START;
            S_OP_START: n_st = S_OP_RUN;
            S_OP_RUN: if (!i_sts.busy) n_st = S_NEXT;
            S_NEXT:   n_st = (r_k == ((r_case == CASE_BOTH) ? 2'd1 : 2'd3)) ? S_OUT : S_OP_START;
            S_OUT:    if (i_out_free) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd.start = (r_st == S_OP_START);
        o_cmd.op = t_op_push; o_cmd.right = 1'b0; o_cmd.value = r_a;
        unique case (r_case)
            CASE_LEFT: unique case (r_k)
                2'd0: begin o_cmd.right = 1'b1; o_cmd.value = r_a; end
                2'd1: o_cmd.op = t_op_pop;
                default: o_cmd.value = r_b;
            endcase
            CASE_RIGHT: unique case (r_k)
                2'd0: o_cmd.value = r_a;
                2'd1: begin o_cmd.op = t_op_pop; o_cmd.right = 1'b1; end
                default: begin o_cmd.right = 1'b1; o_cmd.value = r_b; end
            endcase
            default: if (r_k == 2'd1) begin o_cmd.right = 1'b1; o_cmd.value = r_b; end
        endcase
    end

    assign o_in_ready = (r_st == S_IDLE);
    assign o_out_load = (r_st == S_OUT) && i_out_free;
    assign o_cost = r_cost;
    assign o_ovf = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_loff <= '0; r_roff <= '0; r_cost <= '0; r_started <= 1'b0;
            r_ovf <= 1'b0; r_k <= '0; r_case <= CASE_BOTH;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                S_IDLE: if (i_in_valid) begin
                    r_v <= {{(ValW-32){1'b0}}, i_sample};
                    r_ovf <= (i_sts.lcnt >= CntW'(MaxItems)) || (i_sts.rcnt >= CntW'(MaxItems));
                end
                S_CHECK: if (!r_ovf) begin
                    if (r_started) begin
                        r_loff <= r_loff - {{(ValW-32){1'b0}}, i_step};
                        r_roff <= r_roff + {{(ValW-32){1'b0}}, i_step};
                    end
                    r_started <= 1'b1;
                end
                S_DECIDE: begin
                    r_k <= '0;
                    if (i_sts.lcnt == '0 || i_sts.rcnt == '0) begin
                        r_case <= CASE_BOTH; r_a <= vl; r_b <= vr;
                    end else if ($signed(r_v) <= $signed(ltop)) begin
                        r_case <= CASE_LEFT; r_a <= ltop - r_roff; r_b <= vl;
                        r_cost <= sum[CostW] ? CostMax : sum[CostW-1:0];
                    end else if ($signed(r_v) >= $signed(rtop)) begin
                        r_case <= CASE_RIGHT; r_a <= rtop - r_loff; r_b <= vr;
                        r_cost <= sum[CostW] ? CostMax : sum[CostW-1:0];
                    end else begin
                        r_case <= CASE_BOTH; r_a <= vl; r_b <= vr;
                    end
                end
                S_NEXT: r_k <= r_k + 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// ----- design/bounded_step_l1_fit_cost.sv -----
`timescale 1ns / 1ps
// A rejected sample skips the heap and goes straight to its result beat; an accepted
// one needs two or four heap operations, run one after another. Each heap operation
// sifts one level at a time through a 1024-entry heap, after a command handshake.
// One sample is in flight at a time; the next beat is taken in the cycle after the
// result is loaded.
// Reset (synchronous, active low) clears counts, offsets, cost and step limit;
// heap memory contents are left as they are.
module bounded_step_l1_fit_cost (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // min_cost[53:0], overflow[54], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data      // step_limit[31:0]
);
    import bsl1_pkg::*;

    logic [31:0] r_step;
    t_heap_cmd cmd;
    t_heap_sts sts;
    logic load, ovf, r_ov;
    logic [CostW-1:0] cost;

    // Step limit register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_step <= '0;
        else if (i_cfg_valid) r_step <= i_cfg_data;
    end

    bsl1_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(s_axis_tvalid), .i_sample(s_axis_tdata),
        .i_step(r_step), .i_out_free(!m_axis_tvalid || m_axis_tready), .i_sts(sts),
        .o_in_ready(s_axis_tready), .o_cmd(cmd), .o_out_load(load), .o_cost(cost),
        .o_ovf(ovf)
    );

    bsl1_heap u_heap (.i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts));

    // Output register.
    logic [CostW-1:0] r_oc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (load) m_axis_tvalid <= 1'b1;
        else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        if (load) begin r_oc <= cost; r_ov <= ovf; end
    end
    assign m_axis_tdata = {1'b0, r_ov, r_oc};
endmodule
